// ===== hw/rtl/smo_pkg.sv =====
// ----------------------------------------------------------------------------
// smo_pkg
// Types and constants for the sliding mode back-EMF observer.
// ----------------------------------------------------------------------------
package smo_pkg;

    localparam int QSHIFT   = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IDXW = 3;

    localparam logic [CFG_IDXW-1:0] REG_F_COEFF     = 3'd0;
    localparam logic [CFG_IDXW-1:0] REG_G_COEFF     = 3'd1;
    localparam logic [CFG_IDXW-1:0] REG_ERROR_BOUND = 3'd2;
    localparam logic [CFG_IDXW-1:0] REG_SWITCH_GAIN = 3'd3;
    localparam logic [CFG_IDXW-1:0] REG_LPF_COEFF   = 3'd4;

    typedef struct packed {
        logic signed [15:0] meas_alpha;
        logic signed [15:0] meas_beta;
        logic signed [15:0] volt_alpha;
        logic signed [15:0] volt_beta;
    } t_in;

    typedef struct packed {
        logic signed [15:0] est_cur_alpha;
        logic signed [15:0] est_cur_beta;
        logic signed [15:0] slide_alpha;
        logic signed [15:0] slide_beta;
        logic signed [15:0] emf_alpha;
        logic signed [15:0] emf_beta;
        logic signed [15:0] emf_alpha_final;
        logic signed [15:0] emf_beta_final;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_MF, S_MU, S_MZ, S_ME, S_EST, S_ERR, S_DIV,
        S_DIVEND, S_L1, S_L2, S_NEXT, S_DONE
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)       return 16'sh7fff;
        else if (v < -40'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

endpackage

// ===== hw/rtl/smo_div.sv =====
// ----------------------------------------------------------------------------
// smo_div
// Restoring divider, one quotient bit per cycle, unsigned 30/15 bits.
// ----------------------------------------------------------------------------
module smo_div import smo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_num,
    input  logic [14:0] i_den,
    output logic        o_done,
    output logic [29:0] o_quo
);
    logic [29:0] r_quo, n_quo;
    logic [15:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [15:0] trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem[14:0], r_quo[29]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, i_den}) begin
                n_rem = trial - {1'b0, i_den};
                n_quo = {r_quo[28:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[28:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd29) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_busy && (r_cnt == 5'd29);
    assign o_quo  = n_quo;
endmodule

// ===== hw/rtl/sliding_mode_emf_observer_top.sv =====
// ----------------------------------------------------------------------------
// sliding_mode_emf_observer_top
// Per axis the states S_MF, S_MU, S_MZ, S_ME, S_EST, S_ERR, S_L1, S_L2, S_NEXT
// run, plus a 30-step divide and write-back on an axis whose nonzero error falls
// inside the boundary band. Axes run one after the other through one multiplier.
// One request at a time; the next is accepted the cycle after the result leaves.
// Synchronous active-low reset sets registers to reset values, state to zero.
// ----------------------------------------------------------------------------
module sliding_mode_emf_observer_top import smo_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in                 i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out                o_data,
    input  logic                i_cfg_we,
    input  logic [CFG_IDXW-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data
);
    logic signed [15:0] r_f, r_g;
    logic [14:0] r_zmax, r_k, r_klpf;
    t_state r_st, n_st;
    logic r_ax;
    t_in  r_in;
    t_out r_out;
    logic r_ov;
    logic signed [15:0] r_pe [2], r_pz [2], r_p1 [2], r_p2 [2];
    logic signed [39:0] r_acc;
    logic signed [16:0] r_err;
    logic signed [15:0] r_est, r_z, r_e1;
    logic r_neg;

    logic signed [16:0] ma;
    logic signed [17:0] mb;
    logic signed [34:0] prod;
    logic               div_start, div_done;
    logic [29:0]        div_quo;
    logic [16:0]        mag;
    logic signed [15:0] meas, volt;
    logic signed [39:0] lpsum;
    logic signed [15:0] est_sat;

    assign meas = r_ax ? r_in.meas_beta : r_in.meas_alpha;
    assign volt = r_ax ? r_in.volt_beta : r_in.volt_alpha;
    assign mag  = r_err[16] ? 17'(-r_err) : 17'(r_err);
    assign est_sat = sat16(r_acc >>> QSHIFT);

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_st)
            S_MF:   begin ma = 17'(r_f); mb = 18'(r_pe[r_ax]); end
            S_MU:   begin ma = 17'(r_g); mb = 18'(volt); end
            S_MZ:   begin ma = 17'(r_g); mb = -18'(r_pz[r_ax]); end
            S_ME:   begin ma = 17'(r_g); mb = -18'(r_p1[r_ax]); end
            S_ERR:  begin ma = 17'({2'b0, r_k}); mb = 18'(mag); end
            S_L1:   begin ma = 17'({2'b0, r_klpf}); mb = 18'(r_z) - 18'(r_p1[r_ax]); end
            S_L2:   begin ma = 17'({2'b0, r_klpf}); mb = 18'(r_e1) - 18'(r_p2[r_ax]); end
            default: ;
        endcase
        prod = 35'(ma) * 35'(mb);
    end

    assign lpsum = 40'(prod >>> QSHIFT);
    assign div_start = (r_st == S_ERR) && (mag <= 17'(r_zmax)) && (mag != 0);

    smo_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(prod[29:0]), .i_den(r_zmax), .o_done(div_done), .o_quo(div_quo)
    );

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:   if (i_valid && !r_ov) n_st = S_MF;
            S_MF:     n_st = S_MU;
            S_MU:     n_st = S_MZ;
            S_MZ:     n_st = S_ME;
            S_ME:     n_st = S_EST;
            S_EST:    n_st = S_ERR;
            S_ERR:    n_st = div_start ? S_DIV : S_L1;
            S_DIV:    if (div_done) n_st = S_DIVEND;
            S_DIVEND: n_st = S_L1;
            S_L1:     n_st = S_L2;
            S_L2:     n_st = S_NEXT;
            S_NEXT:   n_st = r_ax ? S_DONE : S_MF;
            S_DONE:   n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_ax <= 1'b0;
            r_f <= 16'sh7fff; r_g <= '0; r_zmax <= 15'h7fff; r_k <= '0; r_klpf <= '0;
            for (int a = 0; a < 2; a++) begin
                r_pe[a] <= '0; r_pz[a] <= '0; r_p1[a] <= '0; r_p2[a] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_F_COEFF:     r_f    <= i_cfg_data;
                    REG_G_COEFF:     r_g    <= i_cfg_data;
                    REG_ERROR_BOUND: r_zmax <= i_cfg_data[14:0];
                    REG_SWITCH_GAIN: r_k    <= i_cfg_data[14:0];
                    REG_LPF_COEFF:   r_klpf <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: begin r_in <= i_data; r_ax <= 1'b0; end
                S_MF:   r_acc <= 40'(prod);
                S_MU, S_MZ, S_ME: r_acc <= r_acc + 40'(prod);
                S_EST: begin
                    r_est <= est_sat;
                    r_err <= 17'(est_sat) - 17'(meas);
                end
                S_ERR: begin
                    r_neg <= r_err[16];
                    if (mag > 17'(r_zmax))
                        r_z <= r_err[16] ? -16'(r_k) : 16'(r_k);
                    else if (!div_start)
                        r_z <= '0;
                end
                S_DIVEND: r_z <= r_neg ? -16'(div_quo) : 16'(div_quo);
                S_L1:   r_e1 <= sat16(40'(r_p1[r_ax]) + lpsum);
                S_L2: begin
                    r_pe[r_ax] <= r_est; r_pz[r_ax] <= r_z; r_p1[r_ax] <= r_e1;
                    r_p2[r_ax] <= sat16(40'(r_p2[r_ax]) + lpsum);
                    if (r_ax) begin
                        r_out.est_cur_beta <= r_est; r_out.slide_beta <= r_z;
                        r_out.emf_beta <= r_e1;
                        r_out.emf_beta_final <= sat16(40'(r_p2[r_ax]) + lpsum);
                    end else begin
                        r_out.est_cur_alpha <= r_est; r_out.slide_alpha <= r_z;
                        r_out.emf_alpha <= r_e1;
                        r_out.emf_alpha_final <= sat16(40'(r_p2[r_ax]) + lpsum);
                    end
                end
                S_NEXT: r_ax <= 1'b1;
                S_DONE: r_ov <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// ===== test/sliding_mode_emf_observer_top_test.sv =====
// ----------------------------------------------------------------------------
// sliding_mode_emf_observer_top_test
// Self-checking bench for the sliding mode back-EMF observer. A driver sends
// requests from a queue, a bit-exact predictor of the estimation, sliding and
// low-pass chain computes each expected result, and a monitor compares
// results field by field under random gaps and stalls. Register settings
// change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_mode_emf_observer_top_test import smo_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_in                 i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_out                o_data;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IDXW-1:0] i_cfg_idx = REG_F_COEFF;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    sliding_mode_emf_observer_top dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor registers and state
    longint f_gain, g_gain, bound, k_gain, lpf_gain;
    longint est_a, est_b, z_a, z_b, e1_a, e1_b, e2_a, e2_b;

    t_in  req_queue[$];
    t_out emf_expected[$];
    int   err_count = 0;
    int   cycles = 0;
    bit   calm = 0;
    int   send_gap = 0;
    int   stall_left = 0;

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint sliding_out(longint est, longint meas);
        longint err;
        err = est - meas;
        if (err > bound) return k_gain;
        if (err < -bound) return -k_gain;
        if (bound == 0) return 0;
        return (k_gain * err) / bound;
    endfunction

    function automatic longint lowpass(longint x, longint e);
        return clip16(e + ((lpf_gain * (x - e)) >>> 15));
    endfunction

    function automatic longint estimate(longint ip, longint u, longint zp, longint ep);
        return clip16((f_gain * ip + g_gain * u - g_gain * zp - g_gain * ep) >>> 15);
    endfunction

    task automatic predict_observer(input t_in req);
        t_out r;
        est_a = estimate(est_a, longint'(req.volt_alpha), z_a, e1_a);
        est_b = estimate(est_b, longint'(req.volt_beta), z_b, e1_b);
        z_a = sliding_out(est_a, longint'(req.meas_alpha));
        z_b = sliding_out(est_b, longint'(req.meas_beta));
        e1_a = lowpass(z_a, e1_a);
        e1_b = lowpass(z_b, e1_b);
        e2_a = lowpass(e1_a, e2_a);
        e2_b = lowpass(e1_b, e2_b);
        r.est_cur_alpha = est_a[15:0];
        r.est_cur_beta = est_b[15:0];
        r.slide_alpha = z_a[15:0];
        r.slide_beta = z_b[15:0];
        r.emf_alpha = e1_a[15:0];
        r.emf_beta = e1_b[15:0];
        r.emf_alpha_final = e2_a[15:0];
        r.emf_beta_final = e2_b[15:0];
        emf_expected.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            err_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            logic sent;
            sent = i_valid && !o_stall;
            if (sent) begin
                predict_observer(i_data);
                send_gap = calm ? 0 : $urandom_range(0, 3);
            end
            if (!i_valid || sent) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    i_data <= req_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (emf_expected.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    t_out e;
                    e = emf_expected.pop_front();
                    check_field("est_cur_alpha", e.est_cur_alpha, o_data.est_cur_alpha);
                    check_field("est_cur_beta", e.est_cur_beta, o_data.est_cur_beta);
                    check_field("slide_alpha", e.slide_alpha, o_data.slide_alpha);
                    check_field("slide_beta", e.slide_beta, o_data.slide_beta);
                    check_field("emf_alpha", e.emf_alpha, o_data.emf_alpha);
                    check_field("emf_beta", e.emf_beta, o_data.emf_beta);
                    check_field("emf_alpha_final", e.emf_alpha_final,
                                o_data.emf_alpha_final);
                    check_field("emf_beta_final", e.emf_beta_final, o_data.emf_beta_final);
                end
                stall_left = calm ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDXW-1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_F_COEFF:     f_gain = longint'($signed(val));
            REG_G_COEFF:     g_gain = longint'($signed(val));
            REG_ERROR_BOUND: bound = val[14:0];
            REG_SWITCH_GAIN: k_gain = val[14:0];
            REG_LPF_COEFF:   lpf_gain = val[14:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int f, input int g, input int eb, input int k,
                            input int lpf);
        cfg_write(REG_F_COEFF, f[15:0]);
        cfg_write(REG_G_COEFF, g[15:0]);
        cfg_write(REG_ERROR_BOUND, eb[15:0]);
        cfg_write(REG_SWITCH_GAIN, k[15:0]);
        cfg_write(REG_LPF_COEFF, lpf[15:0]);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (req_queue.size() > 0 || i_valid || emf_expected.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            3: return 16'($signed($urandom_range(0, 8000)) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic [15:0] ma, mb, va, vb);
        t_in r;
        r.meas_alpha = ma;
        r.meas_beta = mb;
        r.volt_alpha = va;
        r.volt_beta = vb;
        req_queue.push_back(r);
    endtask

    task automatic push_random(input int n);
        repeat (n) push_item(rand_field(), rand_field(), rand_field(), rand_field());
    endtask

    initial begin
        f_gain = 32767; g_gain = 0; bound = 32767; k_gain = 0; lpf_gain = 0;
        est_a = 0; est_b = 0; z_a = 0; z_b = 0;
        e1_a = 0; e1_b = 0; e2_a = 0; e2_b = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        push_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        push_item(16'h0000, 16'hffff, 16'h0001, 16'h0000);
        drain();

        // full gains, narrowest nonzero band, prediction overflow
        set_regs(32767, 32767, 1, 32767, 32767);
        push_item(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        push_item(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        push_item(16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
        push_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();

        // negative extremes, zero boundary band
        set_regs(-32768, -32768, 0, 32767, 16384);
        push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        push_item(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        push_item(16'h1234, 16'hedcb, 16'h0100, 16'hff00);
        drain();

        // wide band, linear region
        set_regs(30000, 1000, 32767, 12000, 1);
        push_item(16'h0010, 16'hfff0, 16'h0400, 16'hfc00);
        push_item(16'h8000, 16'h7fff, 16'h0000, 16'h0000);
        push_item(16'h0005, 16'hfffb, 16'h7fff, 16'h8000);
        push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();

        calm = 1;
        push_random(60);
        drain();
        calm = 0;

        repeat (8) begin
            int eb;
            eb = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 600)
                                             : $urandom_range(1, 32767);
            set_regs($urandom_range(0, 65535), $urandom_range(0, 65535), eb,
                     $urandom_range(0, 32767), $urandom_range(0, 32767));
            push_random(200);
            drain();
        end

        if (err_count == 0 && emf_expected.size() == 0) begin
            $display("end of test: clean");
        end else begin
            if (emf_expected.size() != 0)
                $error("%0d results never arrived", emf_expected.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
